// ----- rtl/hrp_pkg.sv -----
package hrp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FW        = FRAC_BITS + 1;
    localparam int WORK_BITS = 32;
    localparam int LAM_BITS  = 16;
    localparam int LAM_FRAC  = 12;
    localparam int LAM_INT   = LAM_BITS - LAM_FRAC;

    localparam int DIV_STAGES   = (FRAC_BITS + 1) / 2;
    localparam int SQ_STEPS     = 4;
    localparam int SQ_STAGES    = WORK_BITS / SQ_STEPS;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PORE_EXPONENT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IRREDUCIBLE_WATER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_GAS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_OIL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PERMEABILITY  = 3'd4;

    localparam logic [FW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

    typedef logic [FW-1:0]        frac_t;
    typedef logic [WORK_BITS-1:0] work_t;

    typedef struct packed {
        logic [LAM_BITS-1:0] lam;
        frac_t               swi;
        frac_t               sgr;
        frac_t               sor;
        frac_t               kmax;
    } cfg_t;

    // effective saturation handed from the divider to the power unit
    typedef struct packed {
        logic  valid;
        logic  inv;
        frac_t se;
    } se_t;

    typedef struct packed {
        logic  valid;
        logic  inv;
        logic  force_one;
        logic  force_zero;
        logic  acc_one;
        work_t acc;
    } pow_side_t;

    typedef struct packed {
        logic                 valid;
        logic                 inv;
        logic [WORK_BITS:0]   pw;
    } pow_res_t;

endpackage

// ----- rtl/hrp_if.sv -----
interface hrp_in_if;
    import hrp_pkg::*;
    logic  valid;
    logic  ready;
    logic  is_liquid;
    frac_t saturation;
    modport source (output valid, is_liquid, saturation, input ready);
    modport sink (input valid, is_liquid, saturation, output ready);
endinterface

interface hrp_out_if;
    import hrp_pkg::*;
    logic  valid;
    logic  ready;
    frac_t rel_perm;
    logic  invalid_config;
    modport source (output valid, rel_perm, invalid_config, input ready);
    modport sink (input valid, rel_perm, invalid_config, output ready);
endinterface

interface hrp_cfg_if;
    import hrp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    frac_t                data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/hrp_cfg.sv -----
module hrp_cfg
    import hrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hrp_cfg_if.sink   cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.lam  <= LAM_BITS'(8192);
            regs_reg.swi  <= FW'(6554);
            regs_reg.sgr  <= FW'(3277);
            regs_reg.sor  <= FW'(6554);
            regs_reg.kmax <= ONE_Q;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PORE_EXPONENT:     regs_reg.lam  <= cfg.data[LAM_BITS-1:0];
                REG_IRREDUCIBLE_WATER: regs_reg.swi  <= cfg.data;
                REG_RESIDUAL_GAS:      regs_reg.sgr  <= cfg.data;
                REG_RESIDUAL_OIL:      regs_reg.sor  <= cfg.data;
                REG_MAX_PERMEABILITY:  regs_reg.kmax <= cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/hrp_front.sv -----
module hrp_front
    import hrp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  cfg_t    regs,
    input  logic    in_valid,
    input  logic    is_liquid,
    input  frac_t   saturation,
    output se_t     se_out
);

    typedef struct packed {
        logic valid;
        logic inv;
        logic zero;
        logic full;
    } div_flags_t;

    div_flags_t                fl_reg  [0:DIV_STAGES];
    frac_t                     rem_reg [0:DIV_STAGES];
    frac_t                     den_reg [0:DIV_STAGES];
    logic [FRAC_BITS-1:0]      q_reg   [0:DIV_STAGES];

    logic [FW+1:0] sum;
    logic          inv;
    frac_t         den;
    frac_t         resid;
    frac_t         n;
    logic          zero;
    logic          full;

    always_comb
    begin
        sum   = {2'b00, regs.swi} + {2'b00, regs.sgr} + {2'b00, regs.sor};
        inv   = sum >= {2'b00, ONE_Q};
        den   = ONE_Q - sum[FW-1:0];
        resid = is_liquid ? regs.sor : regs.sgr;
        zero  = saturation <= resid;
        n     = saturation - resid;
        full  = n >= den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fl_reg[0].valid <= 1'b0;
        else if (en)
        begin
            fl_reg[0]  <= '{valid: in_valid, inv: inv, zero: zero, full: full};
            rem_reg[0] <= n;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    // restoring division, two quotient bits per stage; rem < den on the live path
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        frac_t                rem_c;
        logic [FRAC_BITS-1:0] q_c;

        always_comb
        begin
            logic [FW:0] t;
            rem_c = rem_reg[s];
            q_c   = q_reg[s];
            for (int j = 0; j < 2; j++)
            begin
                t = {rem_c, 1'b0};
                if (2 * s + j < FRAC_BITS)
                begin
                    if (t >= {1'b0, den_reg[s]})
                    begin
                        t     = t - {1'b0, den_reg[s]};
                        q_c   = {q_c[FRAC_BITS-2:0], 1'b1};
                    end
                    else
                        q_c   = {q_c[FRAC_BITS-2:0], 1'b0};
                    rem_c = t[FW-1:0];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                fl_reg[s+1].valid <= 1'b0;
            else if (en)
            begin
                fl_reg[s+1]  <= fl_reg[s];
                rem_reg[s+1] <= rem_c;
                den_reg[s+1] <= den_reg[s];
                q_reg[s+1]   <= q_c;
            end
        end
    end

    always_comb
    begin
        se_out.valid = fl_reg[DIV_STAGES].valid;
        se_out.inv   = fl_reg[DIV_STAGES].inv;
        if (fl_reg[DIV_STAGES].zero)
            se_out.se = '0;
        else if (fl_reg[DIV_STAGES].full)
            se_out.se = ONE_Q;
        else
            se_out.se = {1'b0, q_reg[DIV_STAGES]};
    end

endmodule

// ----- rtl/hrp_sqrt.sv -----
module hrp_sqrt
    import hrp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  work_t     r_in,
    input  pow_side_t side_in,
    output work_t     r_out,
    output pow_side_t side_out
);

    // floor(sqrt(r * 2^WORK_BITS)), SQ_STEPS result bits per stage
    work_t                 rad_reg  [0:SQ_STAGES-1];
    logic [WORK_BITS+1:0]  rem_reg  [0:SQ_STAGES-1];
    work_t                 res_reg  [0:SQ_STAGES-1];
    pow_side_t             side_reg [0:SQ_STAGES-1];

    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_st
        work_t                rad_i;
        logic [WORK_BITS+1:0] rem_i;
        work_t                res_i;
        pow_side_t            side_i;
        logic [WORK_BITS+3:0] rem_c;
        work_t                res_c;

        if (s == 0)
        begin : g_first
            always_comb
            begin
                rad_i  = r_in;
                rem_i  = '0;
                res_i  = '0;
                side_i = side_in;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                rad_i  = rad_reg[s-1];
                rem_i  = rem_reg[s-1];
                res_i  = res_reg[s-1];
                side_i = side_reg[s-1];
            end
        end

        always_comb
        begin
            logic [2*WORK_BITS-1:0] v;
            logic [WORK_BITS+3:0]   trial;
            logic [1:0]             pair;
            int                     k;
            v     = {rad_i, {WORK_BITS{1'b0}}};
            rem_c = {2'b00, rem_i};
            res_c = res_i;
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                k     = s * SQ_STEPS + j;
                pair  = v[2*WORK_BITS-1-2*k -: 2];
                rem_c = {rem_c[WORK_BITS+1:0], pair};
                trial = {2'b00, res_c, 2'b01};
                if (rem_c >= trial)
                begin
                    rem_c = rem_c - trial;
                    res_c = {res_c[WORK_BITS-2:0], 1'b1};
                end
                else
                    res_c = {res_c[WORK_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[s].valid <= 1'b0;
            else if (en)
            begin
                side_reg[s] <= side_i;
                rad_reg[s]  <= rad_i;
                rem_reg[s]  <= rem_c[WORK_BITS+1:0];
                res_reg[s]  <= res_c;
            end
        end
    end

    assign r_out    = res_reg[SQ_STAGES-1];
    assign side_out = side_reg[SQ_STAGES-1];

endmodule

// ----- rtl/hrp_pow.sv -----
module hrp_pow
    import hrp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  cfg_t     regs,
    input  se_t      se_in,
    output pow_res_t pw_out
);

    function automatic work_t mulhi(input work_t a, input work_t b);
        logic [2*WORK_BITS-1:0] prod;
        prod = {{WORK_BITS{1'b0}}, a} * {{WORK_BITS{1'b0}}, b};
        return prod[2*WORK_BITS-1:WORK_BITS];
    endfunction

    pow_side_t isd_reg [0:LAM_INT];
    work_t     p_reg   [0:LAM_INT];
    work_t     x_reg   [0:LAM_INT];

    pow_side_t fsd_reg [1:LAM_FRAC];
    work_t     r_reg   [1:LAM_FRAC];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            isd_reg[0].valid <= 1'b0;
        else if (en)
        begin
            isd_reg[0].valid      <= se_in.valid;
            isd_reg[0].inv        <= se_in.inv;
            isd_reg[0].force_one  <= (regs.lam == '0) || se_in.se[FRAC_BITS];
            isd_reg[0].force_zero <= se_in.se == '0;
            isd_reg[0].acc_one    <= 1'b1;
            isd_reg[0].acc        <= '0;
            p_reg[0] <= {se_in.se[FRAC_BITS-1:0], {(WORK_BITS-FRAC_BITS){1'b0}}};
            x_reg[0] <= {se_in.se[FRAC_BITS-1:0], {(WORK_BITS-FRAC_BITS){1'b0}}};
        end
    end

    // integer exponent bits: repeated squaring
    for (genvar i = 0; i < LAM_INT; i++)
    begin : g_int
        pow_side_t isd_next;

        always_comb
        begin
            isd_next = isd_reg[i];
            if (regs.lam[LAM_FRAC+i])
            begin
                isd_next.acc_one = 1'b0;
                isd_next.acc     = isd_reg[i].acc_one ? p_reg[i]
                                   : mulhi(isd_reg[i].acc, p_reg[i]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                isd_reg[i+1].valid <= 1'b0;
            else if (en)
            begin
                isd_reg[i+1] <= isd_next;
                p_reg[i+1]   <= mulhi(p_reg[i], p_reg[i]);
                x_reg[i+1]   <= x_reg[i];
            end
        end
    end

    // fractional bits: successive square roots, each followed by a multiply stage
    for (genvar k = 0; k < LAM_FRAC; k++)
    begin : g_frac
        work_t     r_src;
        pow_side_t side_src;
        work_t     sq_r;
        pow_side_t sq_side;
        pow_side_t fsd_next;

        if (k == 0)
        begin : g_first
            assign r_src    = x_reg[LAM_INT];
            assign side_src = isd_reg[LAM_INT];
        end
        else
        begin : g_next
            assign r_src    = r_reg[k];
            assign side_src = fsd_reg[k];
        end

        hrp_sqrt u_sqrt (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .r_in     (r_src),
            .side_in  (side_src),
            .r_out    (sq_r),
            .side_out (sq_side)
        );

        always_comb
        begin
            fsd_next = sq_side;
            if (regs.lam[LAM_FRAC-1-k])
            begin
                fsd_next.acc_one = 1'b0;
                fsd_next.acc     = sq_side.acc_one ? sq_r : mulhi(sq_side.acc, sq_r);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                fsd_reg[k+1].valid <= 1'b0;
            else if (en)
            begin
                fsd_reg[k+1] <= fsd_next;
                r_reg[k+1]   <= sq_r;
            end
        end
    end

    always_comb
    begin
        pw_out.valid = fsd_reg[LAM_FRAC].valid;
        pw_out.inv   = fsd_reg[LAM_FRAC].inv;
        if (fsd_reg[LAM_FRAC].force_one)
            pw_out.pw = {1'b1, {WORK_BITS{1'b0}}};
        else if (fsd_reg[LAM_FRAC].force_zero)
            pw_out.pw = '0;
        else if (fsd_reg[LAM_FRAC].acc_one)
            pw_out.pw = {1'b1, {WORK_BITS{1'b0}}};
        else
            pw_out.pw = {1'b0, fsd_reg[LAM_FRAC].acc};
    end

endmodule

// ----- rtl/hydrocarbon_relative_permeability.sv -----
// Brooks-Corey hydrocarbon relative permeability: rel_perm = kmax * se^lambda, with
// se = (saturation - residual) / (1 - water - gas - oil residuals) clamped to 0..1, all
// Q1.16 except lambda (Q4.12). Fully pipelined, one item per cycle unless stalled:
// 1 + 8 (divider, 2 bits/stage) + 1 + 4 (integer powers) + 12 * 9 (each fractional
// lambda bit is an 8-stage square root plus a multiply) + 1 output stages.
// The whole pipe stalls only while a result sits in the output register unaccepted.
// A residual sum of one or more gives invalid_config = 1 and rel_perm = 0.
// Registers may be written only when the pipeline is empty.
module hydrocarbon_relative_permeability
    import hrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hrp_in_if.sink     din,
    hrp_out_if.source  dout,
    hrp_cfg_if.sink    cfg
);

    cfg_t     regs;
    se_t      se_w;
    pow_res_t pw_w;
    logic     en;

    logic     out_valid_reg;
    frac_t    rel_reg;
    logic     inv_reg;

    assign en        = !out_valid_reg || dout.ready;
    assign din.ready = en;

    hrp_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    hrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .regs       (regs),
        .in_valid   (din.valid),
        .is_liquid  (din.is_liquid),
        .saturation (din.saturation),
        .se_out     (se_w)
    );

    hrp_pow u_pow (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .regs   (regs),
        .se_in  (se_w),
        .pw_out (pw_w)
    );

    logic [FW+WORK_BITS:0] prod;
    frac_t                 rel_next;

    always_comb
    begin
        prod = {{(WORK_BITS+1){1'b0}}, regs.kmax} * {{FW{1'b0}}, pw_w.pw};
        if (pw_w.inv)
            rel_next = '0;
        else if (prod[FW+WORK_BITS:WORK_BITS] > {1'b0, ONE_Q})
            rel_next = ONE_Q;
        else
            rel_next = prod[WORK_BITS+FW-1:WORK_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
        begin
            out_valid_reg <= pw_w.valid;
            rel_reg       <= rel_next;
            inv_reg       <= pw_w.inv;
        end
    end

    assign dout.valid          = out_valid_reg;
    assign dout.rel_perm       = rel_reg;
    assign dout.invalid_config = inv_reg;

endmodule

// ----- bench/hrp_checker.sv -----
module hrp_checker
    import hrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hrp_in_if.sink     din_mon,
    hrp_out_if.sink    dout_mon,
    hrp_cfg_if.sink    cfg_mon,
    output int         fail_count,
    output int         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        frac_t rel_perm;
        logic  invalid_config;
    } perm_result_t;

    logic [LAM_BITS-1:0] lam_q;
    frac_t               swi_q, sgr_q, sor_q, kmax_q;
    perm_result_t        perm_queue[$];

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // se^lambda in Q1.32, 2^32 means one
    function automatic logic [63:0] se_power(input logic [63:0] se, input logic [15:0] lam);
        logic [63:0]  x, acc, p, r;
        logic [127:0] prod;
        if (lam == 0)
            return 64'd1 << 32;
        if (se == 0)
            return 0;
        if (se >= 64'd65536)
            return 64'd1 << 32;
        x = se << 16;
        acc = 64'd1 << 32;
        p = x;
        for (int k = 12; k < 16; k++)
        begin
            if (lam[k])
            begin
                prod = acc * p;
                acc = 64'(prod >> 32);
            end
            prod = p * p;
            p = 64'(prod >> 32);
        end
        r = x;
        for (int k = 11; k >= 0; k--)
        begin
            r = int_sqrt(r << 32);
            if (lam[k])
            begin
                prod = acc * r;
                acc = 64'(prod >> 32);
            end
        end
        return acc;
    endfunction

    function automatic perm_result_t predict_perm(input logic liquid, input frac_t sat);
        perm_result_t res;
        logic [63:0]  sum, denom, resid, se, n, pw, rel;
        sum = 64'(swi_q) + 64'(sgr_q) + 64'(sor_q);
        if (sum >= 64'd65536)
        begin
            res.rel_perm = '0;
            res.invalid_config = 1'b1;
            return res;
        end
        denom = 64'd65536 - sum;
        resid = liquid ? 64'(sor_q) : 64'(sgr_q);
        if (64'(sat) <= resid)
            se = 0;
        else
        begin
            n = 64'(sat) - resid;
            se = (n >= denom) ? 64'd65536 : (n << 16) / denom;
        end
        pw = se_power(se, lam_q);
        rel = (64'(kmax_q) * pw) >> 32;
        if (rel > 64'd65536)
            rel = 64'd65536;
        res.rel_perm = frac_t'(rel);
        res.invalid_config = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        perm_result_t want;
        if (!rst_n)
        begin
            lam_q  <= 16'd8192;
            swi_q  <= 17'd6554;
            sgr_q  <= 17'd3277;
            sor_q  <= 17'd6554;
            kmax_q <= 17'd65536;
            perm_queue.delete();
            pending_count <= 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_mon.index)
                    REG_PORE_EXPONENT:     lam_q  <= cfg_mon.data[LAM_BITS-1:0];
                    REG_IRREDUCIBLE_WATER: swi_q  <= cfg_mon.data;
                    REG_RESIDUAL_GAS:      sgr_q  <= cfg_mon.data;
                    REG_RESIDUAL_OIL:      sor_q  <= cfg_mon.data;
                    REG_MAX_PERMEABILITY:  kmax_q <= cfg_mon.data;
                    default: ;
                endcase
            end
            if (din_mon.valid && din_mon.ready)
                perm_queue.push_back(predict_perm(din_mon.is_liquid, din_mon.saturation));
            if (dout_mon.valid && dout_mon.ready)
            begin
                if (perm_queue.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = perm_queue.pop_front();
                    if (dout_mon.rel_perm !== want.rel_perm)
                        report_mismatch($sformatf("rel_perm got %0d want %0d",
                            dout_mon.rel_perm, want.rel_perm));
                    if (dout_mon.invalid_config !== want.invalid_config)
                        report_mismatch($sformatf("invalid_config got %0b want %0b",
                            dout_mon.invalid_config, want.invalid_config));
                end
            end
            pending_count <= perm_queue.size();
        end
    end
endmodule

// ----- bench/tb_hydrocarbon_relative_permeability.sv -----
module tb_hydrocarbon_relative_permeability;
    import hrp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 123;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending_count;
    int   hold_cycles = 0;
    bit   stim_done = 1'b0;

    hrp_in_if  din();
    hrp_out_if dout();
    hrp_cfg_if cfg();

    hydrocarbon_relative_permeability dut (
        .clk(clk), .rst_n(rst_n), .din(din.sink), .dout(dout.source), .cfg(cfg.sink)
    );

    hrp_checker chk (
        .clk(clk), .rst_n(rst_n), .din_mon(din.sink), .dout_mon(dout.sink),
        .cfg_mon(cfg.sink), .fail_count(fail_count), .pending_count(pending_count)
    );

    always #4 clk = ~clk;

    initial
    begin
        din.valid = 1'b0;
        din.is_liquid = 1'b0;
        din.saturation = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        dout.ready = 1'b0;
    end

    // sink side: random stalls, plus one long hold-off requested by the stimulus
    initial
    begin
        int gap;
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                dout.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 2) == 0)
                gap = 0;
            if (gap > 0)
            begin
                dout.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            dout.ready <= 1'b1;
            @(posedge clk);
            while (!dout.valid)
                @(posedge clk);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input frac_t value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain_pipe();
        din.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic send_sample(input logic liquid, input frac_t sat, input int gap);
        if (gap > 0)
        begin
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din.valid <= 1'b1;
        din.is_liquid <= liquid;
        din.saturation <= sat;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
    endtask

    function automatic frac_t rand_frac();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            3: return frac_t'($urandom_range(65537, 131071));
            default: return frac_t'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic int rand_gap(input bit busy);
        if (busy)
            return 0;
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic random_phase(input int count, input bit busy);
        for (int i = 0; i < count; i++)
            send_sample(1'($urandom_range(0, 1)), rand_frac(), rand_gap(busy));
    endtask

    initial
    begin
        frac_t lam_val;
        #1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, field extremes, both phases
        send_sample(1'b1, 17'd0, 0);
        send_sample(1'b0, 17'd0, 0);
        send_sample(1'b1, 17'd65536, 0);
        send_sample(1'b0, 17'd65536, 0);
        send_sample(1'b1, 17'h1FFFF, 0);
        send_sample(1'b0, 17'd6554, 0);
        send_sample(1'b1, 17'd6554, 0);
        send_sample(1'b1, 17'd6555, 0);
        send_sample(1'b0, 17'd3278, 0);
        send_sample(1'b0, 17'h0AAAA, 0);
        send_sample(1'b1, 17'h15555, 0);
        drain_pipe();

        // zero to the power zero: lambda 0, se 0
        write_reg(REG_PORE_EXPONENT, 17'd0);
        write_reg(REG_IRREDUCIBLE_WATER, 17'd0);
        write_reg(REG_RESIDUAL_GAS, 17'd0);
        write_reg(REG_RESIDUAL_OIL, 17'd0);
        write_reg(REG_MAX_PERMEABILITY, 17'h1FFFF);
        send_sample(1'b0, 17'd0, 0);
        send_sample(1'b1, 17'd12345, 0);
        send_sample(1'b1, 17'h1FFFF, 0);
        drain_pipe();

        // residual sum reaching one
        write_reg(REG_PORE_EXPONENT, 17'hFFFF);
        write_reg(REG_IRREDUCIBLE_WATER, 17'd65536);
        send_sample(1'b0, 17'd40000, 0);
        send_sample(1'b1, 17'h1FFFF, 0);
        drain_pipe();
        write_reg(REG_IRREDUCIBLE_WATER, 17'd20000);
        write_reg(REG_RESIDUAL_GAS, 17'd20000);
        write_reg(REG_RESIDUAL_OIL, 17'd25536);
        send_sample(1'b1, 17'd30000, 0);
        drain_pipe();
        write_reg(REG_RESIDUAL_OIL, 17'd25535);
        send_sample(1'b1, 17'd25536, 0);
        send_sample(1'b0, 17'd65536, 0);
        send_sample(1'b0, 17'd20001, 0);
        drain_pipe();
        // unknown register indexes are ignored
        write_reg(CFG_IDX_W'(5), 17'd1);
        write_reg(CFG_IDX_W'(7), 17'd1);
        send_sample(1'b1, 17'd50000, 0);
        drain_pipe();

        // random phases over several settings
        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph % 4)
                0: lam_val = frac_t'($urandom_range(0, 65535));
                1: lam_val = frac_t'($urandom_range(1, 16384));
                2: lam_val = (ph < 4) ? 17'hFFFF : 17'd1;
                default: lam_val = frac_t'($urandom_range(4096, 12288));
            endcase
            write_reg(REG_PORE_EXPONENT, lam_val);
            write_reg(REG_IRREDUCIBLE_WATER, frac_t'($urandom_range(0, 20000)));
            write_reg(REG_RESIDUAL_GAS, frac_t'($urandom_range(0, 20000)));
            write_reg(REG_RESIDUAL_OIL, frac_t'($urandom_range(0, 20000)));
            write_reg(REG_MAX_PERMEABILITY,
                ($urandom_range(0, 3) == 0) ? frac_t'($urandom_range(0, 131071))
                                            : frac_t'($urandom_range(0, 65536)));
            if (ph == 5)
                write_reg(REG_RESIDUAL_GAS, 17'd65536);
            if (ph == 3)
            begin
                // receiver holds off while the sender keeps pushing past the pipe depth
                hold_cycles = 400;
                random_phase(150, 1'b1);
            end
            else
                random_phase(100, ph % 3 == 0);
            drain_pipe();
        end
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        if (fail_count == 0)
            $display("hydrocarbon_relative_permeability regression: pass");
        else
            $display("hydrocarbon_relative_permeability regression: fail");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("hydrocarbon_relative_permeability regression: fail");
        $finish;
    end
endmodule
